// ----- design/rsvg_pkg.sv -----
package rsvg_pkg;

    localparam int MAX_SEGMENTS    = 1024;
    localparam int TRIG_ITERATIONS = 16;
    localparam int TABLE_LEN       = 24;
    localparam int CORDIC_ITERS    = (TRIG_ITERATIONS < TABLE_LEN) ? TRIG_ITERATIONS : TABLE_LEN;

    localparam int IDX_W  = 10;   // segment index
    localparam int K_W    = 11;   // ring point index, up to 1024
    localparam int NSEG_W = 11;
    localparam int NUM_W  = 28;   // dividend 2*k*sweep + N
    localparam int DEN_W  = 12;   // divisor 2*N
    localparam int QUO_W  = 17;   // quotient, one bit per divider stage
    localparam int XY_W   = 33;   // CORDIC x/y, Q2.30 plus headroom
    localparam int Z_W    = 25;   // CORDIC angle, 2^-24 turns

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic [2:0] REG_NUM_SEGMENTS  = 3'd0;
    localparam logic [2:0] REG_OUTER_RADIUS  = 3'd1;
    localparam logic [2:0] REG_INNER_RADIUS  = 3'd2;
    localparam logic [2:0] REG_SWEEP_ANGLE   = 3'd3;
    localparam logic [2:0] REG_SMOOTH_WEIGHT = 3'd4;

    localparam logic [2:0] VTX_FIRST = 3'd0;
    localparam logic [2:0] VTX_LAST  = 3'd5;

    // effective (clamped) configuration
    typedef struct packed {
        logic [NSEG_W-1:0] num_segments;
        logic [15:0]       outer_radius;
        logic [15:0]       inner_radius;
        logic [16:0]       sweep;
        logic [15:0]       weight;
    } cfg_t;

    // one vertex request from the sequencer to the datapath
    typedef struct packed {
        logic           valid;
        logic [K_W-1:0] k;
        logic           outer;
        logic           last;
    } issue_t;

    typedef struct packed {
        logic next_point;
        logic outer;
    } vtx_kind_t;

    function automatic logic signed [Z_W-1:0] atan_val(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = 25'sd2097152;
            1:       v = 25'sd1238021;
            2:       v = 25'sd654136;
            3:       v = 25'sd332050;
            4:       v = 25'sd166669;
            5:       v = 25'sd83416;
            6:       v = 25'sd41718;
            7:       v = 25'sd20860;
            8:       v = 25'sd10430;
            9:       v = 25'sd5215;
            10:      v = 25'sd2608;
            11:      v = 25'sd1304;
            12:      v = 25'sd652;
            13:      v = 25'sd326;
            14:      v = 25'sd163;
            15:      v = 25'sd81;
            16:      v = 25'sd41;
            17:      v = 25'sd20;
            18:      v = 25'sd10;
            19:      v = 25'sd5;
            20:      v = 25'sd3;
            21:      v = 25'sd1;
            22:      v = 25'sd1;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

    // vertex order: outer i, inner i+1, inner i, inner i+1, outer i, outer i+1
    function automatic vtx_kind_t vertex_kind(input logic [2:0] slot);
        vtx_kind_t v;
        case (slot)
            3'd0:    v = '{next_point: 1'b0, outer: 1'b1};
            3'd1:    v = '{next_point: 1'b1, outer: 1'b0};
            3'd2:    v = '{next_point: 1'b0, outer: 1'b0};
            3'd3:    v = '{next_point: 1'b1, outer: 1'b0};
            3'd4:    v = '{next_point: 1'b0, outer: 1'b1};
            default: v = '{next_point: 1'b1, outer: 1'b1};
        endcase
        return v;
    endfunction

endpackage

// ----- design/rsvg_front.sv -----
module rsvg_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rsvg_pkg::IDX_W-1:0]  segment_index,
    input  logic [rsvg_pkg::NSEG_W-1:0] num_segments,
    input  logic                        pop,
    output logic                        avail,
    output logic [rsvg_pkg::IDX_W-1:0]  head_index
);

    logic [rsvg_pkg::IDX_W-1:0]   mem_reg [0:rsvg_pkg::FIFO_DEPTH-1];
    logic [rsvg_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rsvg_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rsvg_pkg::FIFO_AW:0]   count_reg, count_next;
    logic                         push;
    logic                         in_range;

    assign in_ready   = (count_reg != (rsvg_pkg::FIFO_AW+1)'(rsvg_pkg::FIFO_DEPTH));
    assign avail      = (count_reg != '0);
    assign head_index = mem_reg[rd_ptr_reg];

    // drop indexes outside the ring sector
    assign in_range = ({1'b0, segment_index} < num_segments);
    assign push     = in_valid && in_ready && in_range;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{rsvg_pkg::FIFO_AW{1'b0}}, push}
                    - {{rsvg_pkg::FIFO_AW{1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= segment_index;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (rsvg_pkg::FIFO_AW+1)'(rsvg_pkg::FIFO_DEPTH))
        else $error("queue count above depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> !pop)
        else $error("pop from empty queue");

endmodule

// ----- design/rsvg_seq.sv -----
module rsvg_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       avail,
    input  logic [rsvg_pkg::IDX_W-1:0] head_index,
    input  logic                       adv,
    output logic                       pop,
    output rsvg_pkg::issue_t           issue
);

    logic                       cur_valid_reg;
    logic [rsvg_pkg::IDX_W-1:0] cur_i_reg;
    logic [2:0]                 slot_reg;
    logic                       done;
    rsvg_pkg::vtx_kind_t        kind;

    assign done = adv && cur_valid_reg && (slot_reg == rsvg_pkg::VTX_LAST);
    assign pop  = avail && (!cur_valid_reg || done);
    assign kind = rsvg_pkg::vertex_kind(slot_reg);

    always_comb
    begin
        issue.valid = cur_valid_reg;
        issue.k     = {1'b0, cur_i_reg} + {{(rsvg_pkg::K_W-1){1'b0}}, kind.next_point};
        issue.outer = kind.outer;
        issue.last  = (slot_reg == rsvg_pkg::VTX_LAST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            slot_reg      <= rsvg_pkg::VTX_FIRST;
        end
        else if (pop)
        begin
            cur_valid_reg <= 1'b1;
            slot_reg      <= rsvg_pkg::VTX_FIRST;
        end
        else if (done)
        begin
            cur_valid_reg <= 1'b0;
        end
        else if (adv && cur_valid_reg)
        begin
            slot_reg <= slot_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_i_reg <= head_index;
        end
    end

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (slot_reg <= rsvg_pkg::VTX_LAST))
        else $error("vertex slot out of range");

endmodule

// ----- design/rsvg_datapath.sv -----
module rsvg_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rsvg_pkg::cfg_t           cfg,
    input  rsvg_pkg::issue_t         issue,
    output logic                     adv,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [16:0]       pos_x,
    output logic signed [16:0]       pos_y,
    output logic signed [16:0]       norm_x,
    output logic signed [16:0]       norm_y,
    output logic [15:0]              norm_z,
    output logic [16:0]              tex_u,
    output logic                     tex_v,
    output logic                     last_vertex
);

    localparam int QW = rsvg_pkg::QUO_W;
    localparam int NW = rsvg_pkg::NUM_W;
    localparam int CI = rsvg_pkg::CORDIC_ITERS;
    localparam int XW = rsvg_pkg::XY_W;
    localparam int ZW = rsvg_pkg::Z_W;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    function automatic logic signed [16:0] to_q15(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] t;
        logic signed [XW-1:0] sh;
        logic signed [16:0]   r;
        t  = v + XW'(16384);
        sh = t >>> 15;
        if (sh < -XW'(32768))
            r = -17'sd32768;
        else if (sh > XW'(32768))
            r = 17'sd32768;
        else
            r = sh[16:0];
        return r;
    endfunction

    function automatic logic signed [19:0] round15(input logic signed [33:0] p);
        logic signed [34:0] t;
        logic signed [34:0] sh;
        t  = 35'(p) + 35'sd16384;
        sh = t >>> 15;
        return sh[19:0];
    endfunction

    // ---------------- stage A: capture request ----------------
    logic                      a_valid_reg;
    logic [rsvg_pkg::K_W-1:0]  a_k_reg;
    logic                      a_outer_reg, a_last_reg;

    // ---------------- divider pipeline ----------------
    logic          dv_valid_reg [0:QW];
    logic          dv_outer_reg [0:QW];
    logic          dv_last_reg  [0:QW];
    logic [NW-1:0] dp_rem_reg   [0:QW];
    logic [NW-1:0] du_rem_reg   [0:QW];
    logic [QW-1:0] dp_quo_reg   [0:QW];
    logic [QW-1:0] du_quo_reg   [0:QW];

    logic [NW-1:0] dsh     [0:QW-1];
    logic          gep     [0:QW-1];
    logic          geu     [0:QW-1];
    logic [NW-1:0] kprod;
    logic [NW-1:0] nump, numu;
    logic [rsvg_pkg::DEN_W-1:0] den;

    // ---------------- CORDIC pipeline ----------------
    logic                 c_valid_reg [0:CI];
    logic                 c_outer_reg [0:CI];
    logic                 c_last_reg  [0:CI];
    logic [1:0]           c_quad_reg  [0:CI];
    logic [QW-1:0]        c_u_reg     [0:CI];
    logic signed [XW-1:0] c_x_reg     [0:CI];
    logic signed [XW-1:0] c_y_reg     [0:CI];
    logic signed [ZW-1:0] c_z_reg     [0:CI];
    logic signed [XW-1:0] c_x_next    [0:CI-1];
    logic signed [XW-1:0] c_y_next    [0:CI-1];
    logic signed [ZW-1:0] c_z_next    [0:CI-1];
    logic [15:0]          phase;

    // ---------------- Q, M, output stages ----------------
    logic                 q_valid_reg, q_outer_reg, q_last_reg;
    logic [QW-1:0]        q_u_reg;
    logic signed [16:0]   q_c_reg, q_s_reg;
    logic signed [XW-1:0] map_c, map_s;

    logic                 m_valid_reg, m_outer_reg, m_last_reg;
    logic [QW-1:0]        m_u_reg;
    logic [15:0]          m_nz_reg;
    logic signed [33:0]   m_px_reg, m_py_reg, m_nx_reg, m_ny_reg;
    logic signed [16:0]   rad_s, sw_s;

    logic                 o_valid_reg;
    logic signed [19:0]   rpx, rpy, rnx, rny;

    // whole pipeline holds while the output register is full and not taken
    assign adv       = !o_valid_reg || out_ready;
    assign out_valid = o_valid_reg;

    // dividends and divisor of the two ratios
    always_comb
    begin
        den   = {cfg.num_segments, 1'b0};
        kprod = NW'(a_k_reg) * NW'(cfg.sweep);
        nump  = {kprod[NW-2:0], 1'b0} + NW'(cfg.num_segments);
        numu  = {a_k_reg, 17'b0} + NW'(cfg.num_segments);
    end

    // one restoring quotient bit per stage
    always_comb
    begin
        for (int j = 0; j < QW; j++)
        begin
            dsh[j] = NW'(den) << (QW - 1 - j);
            gep[j] = (dp_rem_reg[j] >= dsh[j]);
            geu[j] = (du_rem_reg[j] >= dsh[j]);
        end
    end

    // CORDIC rotation steps
    assign phase = dp_quo_reg[QW][15:0];

    always_comb
    begin
        for (int i = 0; i < CI; i++)
        begin
            if (c_z_reg[i] >= 0)
            begin
                c_x_next[i] = c_x_reg[i] - (c_y_reg[i] >>> i);
                c_y_next[i] = c_y_reg[i] + (c_x_reg[i] >>> i);
                c_z_next[i] = c_z_reg[i] - rsvg_pkg::atan_val(i);
            end
            else
            begin
                c_x_next[i] = c_x_reg[i] + (c_y_reg[i] >>> i);
                c_y_next[i] = c_y_reg[i] - (c_x_reg[i] >>> i);
                c_z_next[i] = c_z_reg[i] + rsvg_pkg::atan_val(i);
            end
        end
    end

    // quadrant fold
    always_comb
    begin
        case (c_quad_reg[CI])
            QUAD_0:
            begin
                map_c = c_x_reg[CI];
                map_s = c_y_reg[CI];
            end
            QUAD_1:
            begin
                map_c = -c_y_reg[CI];
                map_s = c_x_reg[CI];
            end
            QUAD_2:
            begin
                map_c = -c_x_reg[CI];
                map_s = -c_y_reg[CI];
            end
            default:
            begin
                map_c = c_y_reg[CI];
                map_s = -c_x_reg[CI];
            end
        endcase
    end

    assign rad_s = q_outer_reg ? $signed({1'b0, cfg.outer_radius})
                               : $signed({1'b0, cfg.inner_radius});
    assign sw_s  = $signed({1'b0, cfg.weight});

    assign rpx = round15(m_px_reg);
    assign rpy = round15(m_py_reg);
    assign rnx = round15(m_nx_reg);
    assign rny = round15(m_ny_reg);

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            for (int j = 0; j <= QW; j++)
                dv_valid_reg[j] <= 1'b0;
            for (int i = 0; i <= CI; i++)
                c_valid_reg[i] <= 1'b0;
            q_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg     <= issue.valid;
            dv_valid_reg[0] <= a_valid_reg;
            for (int j = 0; j < QW; j++)
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            c_valid_reg[0] <= dv_valid_reg[QW];
            for (int i = 0; i < CI; i++)
                c_valid_reg[i+1] <= c_valid_reg[i];
            q_valid_reg <= c_valid_reg[CI];
            m_valid_reg <= q_valid_reg;
            o_valid_reg <= m_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_k_reg     <= issue.k;
            a_outer_reg <= issue.outer;
            a_last_reg  <= issue.last;

            dp_rem_reg[0]   <= nump;
            du_rem_reg[0]   <= numu;
            dp_quo_reg[0]   <= '0;
            du_quo_reg[0]   <= '0;
            dv_outer_reg[0] <= a_outer_reg;
            dv_last_reg[0]  <= a_last_reg;
            for (int j = 0; j < QW; j++)
            begin
                dp_rem_reg[j+1]   <= gep[j] ? dp_rem_reg[j] - dsh[j] : dp_rem_reg[j];
                du_rem_reg[j+1]   <= geu[j] ? du_rem_reg[j] - dsh[j] : du_rem_reg[j];
                dp_quo_reg[j+1]   <= {dp_quo_reg[j][QW-2:0], gep[j]};
                du_quo_reg[j+1]   <= {du_quo_reg[j][QW-2:0], geu[j]};
                dv_outer_reg[j+1] <= dv_outer_reg[j];
                dv_last_reg[j+1]  <= dv_last_reg[j];
            end

            c_x_reg[0]     <= rsvg_pkg::CORDIC_GAIN;
            c_y_reg[0]     <= '0;
            c_z_reg[0]     <= $signed({3'b0, phase[13:0], 8'b0});
            c_quad_reg[0]  <= phase[15:14];
            c_u_reg[0]     <= du_quo_reg[QW];
            c_outer_reg[0] <= dv_outer_reg[QW];
            c_last_reg[0]  <= dv_last_reg[QW];
            for (int i = 0; i < CI; i++)
            begin
                c_x_reg[i+1]     <= c_x_next[i];
                c_y_reg[i+1]     <= c_y_next[i];
                c_z_reg[i+1]     <= c_z_next[i];
                c_quad_reg[i+1]  <= c_quad_reg[i];
                c_u_reg[i+1]     <= c_u_reg[i];
                c_outer_reg[i+1] <= c_outer_reg[i];
                c_last_reg[i+1]  <= c_last_reg[i];
            end

            q_c_reg     <= to_q15(map_c);
            q_s_reg     <= to_q15(map_s);
            q_u_reg     <= c_u_reg[CI];
            q_outer_reg <= c_outer_reg[CI];
            q_last_reg  <= c_last_reg[CI];

            m_px_reg    <= q_c_reg * rad_s;
            m_py_reg    <= q_s_reg * rad_s;
            m_nx_reg    <= q_c_reg * sw_s;
            m_ny_reg    <= q_s_reg * sw_s;
            m_nz_reg    <= q_outer_reg ? 16'(17'd32768 - {1'b0, cfg.weight}) : 16'h8000;
            m_u_reg     <= q_u_reg;
            m_outer_reg <= q_outer_reg;
            m_last_reg  <= q_last_reg;

            if (rpx < -20'sd65536)
                pos_x <= -17'sd65536;
            else if (rpx > 20'sd65535)
                pos_x <= 17'sd65535;
            else
                pos_x <= rpx[16:0];
            if (rpy < -20'sd65536)
                pos_y <= -17'sd65536;
            else if (rpy > 20'sd65535)
                pos_y <= 17'sd65535;
            else
                pos_y <= rpy[16:0];
            norm_x      <= m_outer_reg ? rnx[16:0] : 17'sd0;
            norm_y      <= m_outer_reg ? rny[16:0] : 17'sd0;
            norm_z      <= m_nz_reg;
            tex_u       <= m_u_reg;
            tex_v       <= m_outer_reg;
            last_vertex <= m_last_reg;
        end
    end

    a_last_outer: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_vertex) |-> tex_v)
        else $error("last vertex not on outer ring");

    a_inner_normal: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !tex_v) |-> (norm_z == 16'h8000 && norm_x == 17'sd0 && norm_y == 17'sd0))
        else $error("inner vertex normal not +z");

endmodule

// ----- design/ring_sector_vertex_generator.sv -----
// An accepted segment index is queued and taken by the sequencer; each of its six
// vertices then passes stage A, the divider, CORDIC, Q and M stages and the output register.
// Throughput: one vertex per cycle while out_ready is held high; the vertex pipeline
// (17 divider stages, CORDIC stages, multiply, round) issues one point a cycle.
// Reset: rst_n clears the index queue, sequencer and pipeline valid bits, and loads the
// configuration defaults (20 segments, radii 8192/1638, full sweep, weight 0.5).
module ring_sector_vertex_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [9:0]         segment_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [16:0] pos_x,
    output logic signed [16:0] pos_y,
    output logic signed [16:0] norm_x,
    output logic signed [16:0] norm_y,
    output logic [15:0]        norm_z,
    output logic [16:0]        tex_u,
    output logic               tex_v,
    output logic               last_vertex
);

    // Configuration registers; writing them only while the block is idle is up to the user.
    logic [10:0] num_segments_reg;
    logic [15:0] outer_radius_reg;
    logic [15:0] inner_radius_reg;
    logic [16:0] sweep_angle_reg;
    logic [15:0] smooth_weight_reg;

    rsvg_pkg::cfg_t   cfg;
    rsvg_pkg::issue_t issue;
    logic             pop;
    logic             avail;
    logic             adv;
    logic [9:0]       head_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_segments_reg  <= 11'd20;
            outer_radius_reg  <= 16'd8192;
            inner_radius_reg  <= 16'd1638;
            sweep_angle_reg   <= 17'd65536;
            smooth_weight_reg <= 16'd16384;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rsvg_pkg::REG_NUM_SEGMENTS:  num_segments_reg  <= cfg_data[10:0];
                rsvg_pkg::REG_OUTER_RADIUS:  outer_radius_reg  <= cfg_data[15:0];
                rsvg_pkg::REG_INNER_RADIUS:  inner_radius_reg  <= cfg_data[15:0];
                rsvg_pkg::REG_SWEEP_ANGLE:   sweep_angle_reg   <= cfg_data;
                rsvg_pkg::REG_SMOOTH_WEIGHT: smooth_weight_reg <= cfg_data[15:0];
                default:                     ;
            endcase
        end
    end

    // Clamp the segment count, sweep and weight to their legal ranges. A count of
    // zero rejects every index in the front end.
    always_comb
    begin
        cfg.num_segments = (32'(num_segments_reg) > rsvg_pkg::MAX_SEGMENTS)
                         ? 11'(rsvg_pkg::MAX_SEGMENTS) : num_segments_reg;
        cfg.outer_radius = outer_radius_reg;
        cfg.inner_radius = inner_radius_reg;
        cfg.sweep        = (sweep_angle_reg > 17'd65536) ? 17'd65536 : sweep_angle_reg;
        cfg.weight       = (smooth_weight_reg > 16'd32768) ? 16'd32768 : smooth_weight_reg;
    end

    // Front end: accept each transaction, drop out-of-range indexes, queue the rest.
    rsvg_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .segment_index (segment_index),
        .num_segments  (cfg.num_segments),
        .pop           (pop),
        .avail         (avail),
        .head_index    (head_index)
    );

    // Sequencer: walk the six vertex slots of the head segment, one per advance.
    rsvg_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .avail      (avail),
        .head_index (head_index),
        .adv        (adv),
        .pop        (pop),
        .issue      (issue)
    );

    // Back end: phase and texture ratios, CORDIC, scaling and rounding per vertex.
    rsvg_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .issue       (issue),
        .adv         (adv),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .norm_x      (norm_x),
        .norm_y      (norm_y),
        .norm_z      (norm_z),
        .tex_u       (tex_u),
        .tex_v       (tex_v),
        .last_vertex (last_vertex)
    );

endmodule
